### rtl/emst_pkg.sv
// Shared types and constants for the Euclidean spanning tree block.
// No dependencies; imported by every module under rtl.
package emst_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int CW   = 16;     // coordinate width
    localparam int DW   = 34;     // squared distance width
    localparam int LW   = 25;     // edge length width
    localparam int TW   = 33;     // total length width
    localparam int PW   = 7;      // point count width
    localparam logic [DW-1:0] DIST_INF = {DW{1'b1}};

    typedef struct packed {
        logic load;         // write the incoming point
        logic init;         // clear tree state for a new run
        logic relax;        // update candidate k against the last added point
        logic scan;         // compare candidate k against the running minimum
        logic scan_clr;     // start a new minimum search
        logic add_pick;     // add the chosen point to the tree
        logic sqrt_start;   // start the root of the chosen distance
        logic accum;        // add the finished root to the totals
    } emst_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic found;
    } emst_sts_t;

endpackage

### rtl/emst_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on emst_pkg.
module emst_sqrt
    import emst_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] d2,
    output logic          done,
    output logic [LW-1:0] root
);
    // Root of d2 * 2^16: a 50-bit radicand gives a 25-bit root.
    localparam int RW = 2 * LW;

    logic [RW-1:0] rad_reg, rad_next;
    logic [LW+1:0] rem_reg, rem_next;
    logic [LW-1:0] root_reg, root_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [LW+1:0] trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            rad_next  = {d2, 16'd0};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = {rem_reg[LW-1:0], rad_reg[RW-1 -: 2]};
            trial    = {root_reg, 2'b01};
            rad_next = {rad_reg[RW-3:0], 2'b00};
            if (rem_next >= trial)
            begin
                rem_next  = rem_next - trial;
                root_next = {root_reg[LW-2:0], 1'b1};
            end
            else
            begin
                root_next = {root_reg[LW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(LW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

### rtl/emst_datapath.sv
// Point store, candidate distances, minimum search and length totals.
// Depends on emst_pkg and emst_sqrt.
module emst_datapath
    import emst_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int AW = $clog2(MAX_POINTS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  emst_cmd_t             cmd,
    output emst_sts_t             sts,
    input  logic [AW-1:0]         wr_idx,
    input  logic [AW-1:0]         k_idx,
    input  logic signed [CW-1:0]  in_x,
    input  logic signed [CW-1:0]  in_y,
    output logic [TW-1:0]         total,
    output logic [LW-1:0]         longest
);
    logic signed [CW-1:0] xs_mem [MAX_POINTS];
    logic signed [CW-1:0] ys_mem [MAX_POINTS];
    logic [DW-1:0]        best_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] in_tree_reg;

    logic signed [CW-1:0] ux_reg, uy_reg;        // last point added
    logic [AW-1:0]        pick_reg;
    logic                 found_reg;
    logic [DW-1:0]        min_reg;
    logic [TW-1:0]        total_reg;
    logic [LW-1:0]        longest_reg;

    logic signed [CW-1:0] xk_reg, yk_reg;
    logic [DW-1:0]        bk_reg;
    logic [AW-1:0]        kd_reg;
    logic                 relax_d_reg;
    logic                 scan_d_reg;
    logic                 sqrt_go_reg;
    logic [AW-1:0]        u_idx;

    logic signed [CW:0]   dx, dy;
    logic [2*CW+1:0]      sqx, sqy;
    logic [DW-1:0]        gap_d2;
    logic                 sq_done;
    logic [LW-1:0]        root;

    // Candidate k is read into registers and updated or compared in the following
    // cycle, so the relax and scan passes act on kd_reg, the registered copy of k_idx.
    assign u_idx  = cmd.add_pick ? pick_reg : '0;
    assign dx     = (CW+1)'(xk_reg) - (CW+1)'(ux_reg);
    assign dy     = (CW+1)'(yk_reg) - (CW+1)'(uy_reg);
    assign sqx    = (2*CW+2)'(dx * dx);
    assign sqy    = (2*CW+2)'(dy * dy);
    assign gap_d2 = DW'(sqx) + DW'(sqy);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xs_mem[wr_idx] <= in_x;
            ys_mem[wr_idx] <= in_y;
        end
        xk_reg <= xs_mem[k_idx];
        yk_reg <= ys_mem[k_idx];
        bk_reg <= best_mem[k_idx];
        kd_reg <= k_idx;
        if (relax_d_reg && !in_tree_reg[kd_reg] && gap_d2 < bk_reg)
            best_mem[kd_reg] <= gap_d2;
        else if (cmd.init)
            best_mem[k_idx] <= DIST_INF;
        if ((cmd.init && k_idx == '0) || cmd.add_pick)
        begin
            ux_reg <= xs_mem[u_idx];
            uy_reg <= ys_mem[u_idx];
        end
        if (cmd.scan_clr)
            min_reg <= DIST_INF;
        else if (scan_d_reg && !in_tree_reg[kd_reg]
                 && (!found_reg || bk_reg < min_reg))
        begin
            min_reg  <= bk_reg;
            pick_reg <= kd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tree_reg <= '0;
            found_reg   <= 1'b0;
            total_reg   <= '0;
            longest_reg <= '0;
            relax_d_reg <= 1'b0;
            scan_d_reg  <= 1'b0;
            sqrt_go_reg <= 1'b0;
        end
        else
        begin
            relax_d_reg <= cmd.relax;
            scan_d_reg  <= cmd.scan;
            sqrt_go_reg <= cmd.sqrt_start;
            if (cmd.init)
            begin
                in_tree_reg <= MAX_POINTS'(1);
                total_reg   <= '0;
                longest_reg <= '0;
            end
            if (cmd.add_pick)
                in_tree_reg[pick_reg] <= 1'b1;
            if (cmd.scan_clr)
                found_reg <= 1'b0;
            else if (scan_d_reg && !in_tree_reg[kd_reg])
                found_reg <= 1'b1;
            if (cmd.accum)
            begin
                total_reg <= total_reg + TW'(root);
                if (root > longest_reg)
                    longest_reg <= root;
            end
        end
    end

    // The root start is registered from the request so that the last compare
    // of the scan has reached min_reg.
    emst_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_go_reg),
        .d2    (min_reg),
        .done  (sq_done),
        .root  (root)
    );

    assign sts.sqrt_done = sq_done;
    assign sts.found     = found_reg;
    assign total         = total_reg;
    assign longest       = longest_reg;
endmodule

### rtl/emst_ctrl.sv
// Sequencer for point loading and Prim's tree growth.
// Depends on emst_pkg; drives emst_datapath through command signals.
module emst_ctrl
    import emst_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int AW = $clog2(MAX_POINTS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_last,
    input  logic          out_ready,
    output logic          out_valid,
    output emst_cmd_t     cmd,
    input  emst_sts_t     sts,
    output logic [AW-1:0] wr_idx,
    output logic [AW-1:0] k_idx,
    output logic [PW-1:0] count,
    output logic          dropped
);
    typedef enum logic [7:0] {
        S_LOAD  = 8'b00000001,
        S_INIT  = 8'b00000010,
        S_RELAX = 8'b00000100,
        S_SCAN  = 8'b00001000,
        S_PICK  = 8'b00010000,
        S_ROOT  = 8'b00100000,
        S_ADD   = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t        state_reg, state_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic          drop_reg, drop_next;
    logic [AW-1:0] k_reg, k_next;
    logic [PW-1:0] step_reg, step_next;
    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] out_count_reg, out_count_next;
    logic          out_drop_reg, out_drop_next;
    logic          take, k_end;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = out_valid_reg;
    assign take      = in_valid && in_ready;
    assign k_end     = (PW'(k_reg) == cnt_reg - PW'(1));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_count_next = out_count_reg;
        out_drop_next  = out_drop_reg;
        cmd            = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (take)
                begin
                    if (cnt_reg < PW'(MAX_POINTS))
                    begin
                        cmd.load = 1'b1;
                        cnt_next = cnt_reg + PW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        k_next     = '0;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                // The totals of a result still waiting must not be cleared.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.init = 1'b1;
                    k_next   = k_reg + AW'(1);
                    if (PW'(k_reg) == cnt_next - PW'(1) || cnt_reg == '0)
                    begin
                        k_next     = '0;
                        step_next  = PW'(1);
                        state_next = (cnt_reg > PW'(1)) ? S_RELAX : S_OUT;
                    end
                end
            end
            S_RELAX:
            begin
                cmd.relax = 1'b1;
                k_next    = k_reg + AW'(1);
                if (k_end)
                begin
                    k_next       = '0;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                k_next   = k_reg + AW'(1);
                if (k_end)
                begin
                    k_next     = '0;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.accum  = 1'b1;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add_pick = 1'b1;
                step_next    = step_reg + PW'(1);
                state_next   = (step_reg + PW'(1) == cnt_reg) ? S_OUT : S_RELAX;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = cnt_reg;
                    out_drop_next  = drop_reg;
                    cnt_next       = '0;
                    drop_next      = 1'b0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            k_reg         <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
            out_drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
            k_reg         <= k_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
            out_drop_reg  <= out_drop_next;
        end
    end

    assign wr_idx  = cnt_reg[AW-1:0];
    assign k_idx   = k_reg;
    assign count   = out_count_reg;
    assign dropped = out_drop_reg;
endmodule

### rtl/euclidean_prim_spanning_tree.sv
// Euclidean minimum spanning tree (Prim) over up to MAX_POINTS streamed points.
// Points load at one word per cycle. After the last point the candidates are cleared,
// then each step scans all loaded points twice (update and minimum), launches the
// bit-serial square root of the minimum, adds the root to the totals and adds the
// picked point to the tree. Input is held off meanwhile; a result waits in its
// register while the next set loads. rst_n clears counts and flags.
module euclidean_prim_spanning_tree
    import emst_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // coord_x[15:0], coord_y[31:16]
    input  logic        s_tlast,   // final_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // tree_length[32:0], longest_edge[57:33],
                                   // points_used[64:58], overflowed[65], zero fill
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    emst_cmd_t     cmd;
    emst_sts_t     sts;
    logic [AW-1:0] wr_idx, k_idx;
    logic [PW-1:0] count;
    logic          dropped;
    logic [TW-1:0] total;
    logic [LW-1:0] longest;

    emst_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd),
        .sts       (sts),
        .wr_idx    (wr_idx),
        .k_idx     (k_idx),
        .count     (count),
        .dropped   (dropped)
    );

    emst_datapath #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .wr_idx  (wr_idx),
        .k_idx   (k_idx),
        .in_x    (s_tdata[15:0]),
        .in_y    (s_tdata[31:16]),
        .total   (total),
        .longest (longest)
    );

    assign m_tdata = {6'd0, dropped, count, longest, total};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while waiting");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count <= PW'(MAX_POINTS)) else $error("point count beyond capacity");
    a_longest: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> TW'(longest) <= total) else $error("longest edge above total");
endmodule
